>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file imports it.
`default_nettype none

package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic  ins;    // place value at its sorted position, shift smaller ones down
    logic  rem;    // shift everything one toward the head
    data_t value;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/spq_ifs.sv
// Valid/ready channel interfaces for the queue's operation and result beats.
// Depends on spq_pkg.
`default_nettype none

interface spq_in_if import spq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  data_t               value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
  logic                valid;
  logic                ready;
  data_t               head_value;
  data_t               tail_value;
  data_t               removed_value;
  logic                is_empty;
  logic [OCC_W-1:0]    occupancy;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output head_value, output tail_value,
                  output removed_value, output is_empty, output occupancy,
                  output status, input ready);
  modport sink   (input valid, input head_value, input tail_value,
                  input removed_value, input is_empty, input occupancy,
                  input status, output ready);
endinterface

`default_nettype wire

>>> design/spq_cell.sv
// One slot of the sorted row: holds a value and trades with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occ,
  input  wire data_t     left_val,
  input  wire logic      left_belongs,
  input  wire data_t     right_val,
  output data_t          slot_val,
  output data_t          slot_nxt,
  output logic           belongs
);

  data_t slot_r;

  // New value sits at or ahead of this slot.
  assign belongs = !occ || (ctl.value > slot_r);

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.ins) begin
      if (left_belongs) begin
        slot_nxt = left_val;
      end else if (belongs) begin
        slot_nxt = ctl.value;
      end
    end else if (ctl.rem) begin
      slot_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_val = slot_r;

endmodule

`default_nettype wire

>>> design/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a row of compare-and-shift cells,
// a fill counter and a registered result stage.
// Depends on spq_pkg, spq_ifs and spq_cell.
`default_nettype none

// Sorted priority queue. Holds up to QUEUE_DEPTH signed 32-bit values in
// descending order, largest at the head. Each operation beat is insert,
// remove head or clear; a new value lands behind any equal values already
// stored, so equal values leave in arrival order. Every operation yields
// exactly one result beat reporting head, tail, removed value, empty flag,
// occupancy and status (ok, removal from empty, insert into full dropped).
// Every cell compares the new value against its own slot in parallel and
// shifts in the same edge, and the result is held in an output register, so
// a new operation is taken each cycle as long as the result side keeps
// draining. The result appears in the cycle after its operation is taken.
// Contents of slots beyond the fill count are never shown.
module sorted_priority_queue_core import spq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;

  logic             accept;
  logic             is_full;
  logic             is_empty_now;
  cell_ctl_t        ctl;

  data_t            slot_val  [QUEUE_DEPTH];
  data_t            slot_nxt  [QUEUE_DEPTH];
  logic             belongs   [QUEUE_DEPTH];
  logic             occ       [QUEUE_DEPTH];

  // Accept a new beat whenever the result register is free or draining.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;

  assign is_full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty_now = (count_r == '0);

  always_comb begin
    ctl.ins   = accept && (in_ch.mode == MODE_INSERT) && !is_full;
    ctl.rem   = accept && (in_ch.mode == MODE_REMOVE) && !is_empty_now;
    ctl.value = in_ch.value;
  end

  // The cell row: each slot looks left on insert and right on removal.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    data_t left_val;
    logic  left_belongs;
    data_t right_val;

    assign occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_val     = slot_val[i];
      assign left_belongs = 1'b0;
    end else begin : g_mid
      assign left_val     = slot_val[i-1];
      assign left_belongs = belongs[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_val = slot_val[i];
    end else begin : g_body
      assign right_val = slot_val[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occ          (occ[i]),
      .left_val     (left_val),
      .left_belongs (left_belongs),
      .right_val    (right_val),
      .slot_val     (slot_val[i]),
      .slot_nxt     (slot_nxt[i]),
      .belongs      (belongs[i])
    );
  end

  // Fill counter follows the operation; hold on idle cycles.
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      case (in_ch.mode)
        MODE_INSERT: if (!is_full)      count_nxt = count_r + CNT_W'(1);
        MODE_REMOVE: if (!is_empty_now) count_nxt = count_r - CNT_W'(1);
        MODE_CLEAR:  count_nxt = '0;
        default:     count_nxt = count_r;
      endcase
    end
  end

  // Result fields, computed from the state after this operation.
  data_t               head_nxt;
  data_t               tail_nxt;
  data_t               removed_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic [CNT_W-1:0]    tail_pos;
  logic [IDX_W-1:0]    tail_idx;

  assign tail_pos = count_nxt - CNT_W'(1);
  assign tail_idx = tail_pos[IDX_W-1:0];

  always_comb begin
    head_nxt    = '0;
    tail_nxt    = '0;
    removed_nxt = '0;
    status_nxt  = STATUS_OK;
    if (count_nxt != '0) begin
      head_nxt = slot_nxt[0];
      tail_nxt = slot_nxt[tail_idx];
    end
    case (in_ch.mode)
      MODE_INSERT: if (is_full) status_nxt = STATUS_FULL;
      MODE_REMOVE: begin
        if (is_empty_now) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          removed_nxt = slot_val[0];
        end
      end
      default: status_nxt = STATUS_OK;
    endcase
  end

  data_t               head_r;
  data_t               tail_r;
  data_t               removed_r;
  logic                empty_r;
  logic [OCC_W-1:0]    occ_r;
  logic [STATUS_W-1:0] status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload needs no reset; load it with each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      removed_r <= removed_nxt;
      empty_r   <= (count_nxt == '0);
      occ_r     <= OCC_W'(count_nxt);
      status_r  <= status_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.head_value    = head_r;
  assign out_ch.tail_value    = tail_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.is_empty      = empty_r;
  assign out_ch.occupancy     = occ_r;
  assign out_ch.status        = status_r;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for sorted_priority_queue_core: drives insert, remove,
// clear and unused-mode beats and checks every result beat against a local predictor.
// Depends on spq_pkg, spq_ifs and the design files of the queue.
`default_nettype none

module tb_top;
  import spq_pkg::*;

  // The unused mode code; the block must treat it as a no-op.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One result beat, field by field, as the block reports it.
  typedef struct packed {
    data_t               head;
    data_t               tail;
    data_t               removed;
    logic                empty;
    logic [OCC_W-1:0]    occ;
    logic [STATUS_W-1:0] status;
  } queue_report_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  sorted_priority_queue_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predictor state: stored values in descending order and their count.
  data_t         model_slots [QUEUE_DEPTH];
  int unsigned   model_fill;
  queue_report_t pending_reports [$];

  int error_count;
  int send_idle_pct;   // chance in a hundred that the sender idles a cycle
  int recv_stall_pct;  // chance in a hundred that the receiver drops ready
  int hold_cycles;     // long receiver hold-off, picked up by the receiver process

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the predictor and return the beat it must cause.
  function automatic queue_report_t apply_queue_op(input logic [MODE_W-1:0] mode,
                                                   input data_t value);
    queue_report_t rpt;
    int unsigned   pos;
    rpt = '0;
    rpt.status = STATUS_OK;
    if (mode == MODE_INSERT) begin
      if (model_fill >= QUEUE_DEPTH) begin
        rpt.status = STATUS_FULL;  // drop the value, keep the queue as it is
      end else begin
        // Land behind every equal value: stop at the first strictly smaller one.
        pos = model_fill;
        for (int k = model_fill - 1; k >= 0; k--) begin
          if (value > model_slots[k]) pos = k;
        end
        for (int k = model_fill; k > pos; k--) model_slots[k] = model_slots[k-1];
        model_slots[pos] = value;
        model_fill++;
      end
    end else if (mode == MODE_REMOVE) begin
      if (model_fill == 0) begin
        rpt.status = STATUS_EMPTY;
      end else begin
        rpt.removed = model_slots[0];
        for (int k = 1; k < model_fill; k++) model_slots[k-1] = model_slots[k];
        model_fill--;
      end
    end else if (mode == MODE_CLEAR) begin
      model_fill = 0;
    end
    // MODE_UNUSED falls through: queue unchanged, status ok.
    if (model_fill != 0) begin
      rpt.head = model_slots[0];
      rpt.tail = model_slots[model_fill-1];
    end
    rpt.empty  = (model_fill == 0);
    rpt.occ    = model_fill[OCC_W-1:0];
    return rpt;
  endfunction

  // Offer one operation beat, idling first at the current rate. Valid stays high
  // after acceptance so that back-to-back beats need no second assignment.
  task automatic send_op(input logic [MODE_W-1:0] mode, input data_t value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.value <= value;
    do @(posedge clk); while (!in_if.ready);
    pending_reports.push_back(apply_queue_op(mode, value));
  endtask

  // Drop valid and hold until every predicted beat has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Extremes, a narrow band around zero so equal values collide often, and random values.
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return data_t'($signed($urandom_range(0, 8)) - 4);
      default: return data_t'($urandom);
    endcase
  endfunction

  // Random operations; insert_pct steers the queue toward full or toward empty.
  task automatic send_random_ops(input int count, input int insert_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)                    send_op(MODE_CLEAR, pick_value());
      else if (r < 6)               send_op(MODE_UNUSED, pick_value());
      else if (r < 6 + insert_pct)  send_op(MODE_INSERT, pick_value());
      else                          send_op(MODE_REMOVE, pick_value());
    end
  endtask

  // Extremes, duplicates, removal from empty, insert into full, clear, unused mode.
  task automatic test_edge_cases();
    data_t fill_vals [QUEUE_DEPTH] = '{
      32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, 32'sd7, 32'sd7, -32'sd7,
      32'sh7fff_fffe, 32'sh8000_0001, 32'sh0, 32'sd100, -32'sd100, 32'sd7,
      32'sh5555_5555, 32'shAAAA_AAAA};
    send_op(MODE_REMOVE, 32'sh0);
    send_op(MODE_UNUSED, 32'sh7fff_ffff);
    foreach (fill_vals[i]) send_op(MODE_INSERT, fill_vals[i]);
    send_op(MODE_INSERT, 32'sh7fff_ffff);   // full: must be dropped
    send_op(MODE_UNUSED, 32'sh8000_0000);
    send_op(MODE_REMOVE, 32'sh0);
    send_op(MODE_REMOVE, 32'sh0);
    send_op(MODE_CLEAR, -32'sd1);
    send_op(MODE_REMOVE, 32'sh0);           // empty again after clear
  endtask

  // One idle phase: sweep the fill level up, through the middle and down.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random_ops(80, 75);
    send_random_ops(80, 45);
    send_random_ops(80, 30);
  endtask

  // Hold off the receiver while inserts keep coming so the block backs up
  // and deasserts ready on the input side.
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 60;
    for (int i = 0; i < 20; i++) send_op(MODE_INSERT, pick_value());
    for (int i = 0; i < 20; i++) send_op(MODE_REMOVE, pick_value());
  endtask

  // Let the result side empty completely mid-stream, then resume.
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    send_random_ops(10, 60);
    wait_drained();
    send_random_ops(10, 40);
  endtask

  // Receiver: random ready, with a long counted hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic flag_mismatch(input string field, input int exp_v, input int got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    error_count++;
  endtask

  // Check every accepted result beat against the oldest prediction.
  queue_report_t exp_r;
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with nothing expected, head %0d status %0d",
                 $time, out_if.head_value, out_if.status);
        error_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (out_if.head_value !== exp_r.head)
          flag_mismatch("head_value", exp_r.head, out_if.head_value);
        if (out_if.tail_value !== exp_r.tail)
          flag_mismatch("tail_value", exp_r.tail, out_if.tail_value);
        if (out_if.removed_value !== exp_r.removed)
          flag_mismatch("removed_value", exp_r.removed, out_if.removed_value);
        if (out_if.is_empty !== exp_r.empty)
          flag_mismatch("is_empty", exp_r.empty, out_if.is_empty);
        if (out_if.occupancy !== exp_r.occ)
          flag_mismatch("occupancy", exp_r.occ, out_if.occupancy);
        if (out_if.status !== exp_r.status)
          flag_mismatch("status", exp_r.status, out_if.status);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int waited;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    model_fill     = 0;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.mode  <= MODE_INSERT;
    in_if.value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_cases();
    test_random_traffic(0, 0);
    test_backpressure_fill();
    test_random_traffic(52, 0);
    test_drain_pause();
    test_random_traffic(0, 52);
    test_random_traffic(11, 11);

    // Drain: wait for the last beats, then wait on for any stray one.
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending_reports.size());
      error_count++;
    end
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
